// File: rtl/sdsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared types and constants of the dead-block and stream aware replacement
// policy.
// ----------------------------------------------------------------------------
package sdsr_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int SIGNATURE_BITS = 6;
    localparam int SIG_ENTRIES    = 1 << SIGNATURE_BITS;
    localparam int SET_W          = 11;
    localparam int WAY_W          = 4;
    localparam int CNT_W          = SET_W + 1;
    localparam int PERIOD_W       = 20;

    localparam logic [1:0] CTR_MAX          = 2'd3;
    localparam logic [1:0] STREAM_THRESHOLD = 2'd2;
    localparam logic [1:0] REUSE_THRESHOLD  = 2'd2;
    localparam logic [PERIOD_W-1:0] DECAY_RESET = 20'd100000;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic [63:0] pc;
        logic [63:0] paddr;
        logic        hit;
    } in_word_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       chose_dead;
        logic       streaming_insert;
    } out_word_t;

    // All state of one set, kept as one memory row.
    typedef struct packed {
        logic [NUM_WAYS-1:0][1:0]                rrpv;
        logic [NUM_WAYS-1:0][1:0]                dead;
        logic [NUM_WAYS-1:0][SIGNATURE_BITS-1:0] sig;
        logic [SIG_ENTRIES-1:0][1:0]             reuse;
        logic [1:0]                              stream;
        logic [63:0]                             prev_addr;
        logic [63:0]                             prev_stride;
    } row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DECAY
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             exec;
        logic             clr_wr;
        logic             swp_rd;
        logic             swp_wr;
        logic [SET_W-1:0] cnt_row;
        logic [SET_W-1:0] prev_row;
    } cmd_t;

    typedef struct packed {
        logic decay_req;
    } status_t;

endpackage

// File: rtl/sdsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sdsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsr_ctrl
// Sequencer: clearing pass, item read and execute, and the decay sweep.
// ----------------------------------------------------------------------------
module sdsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sdsr_pkg::status_t status,
    output logic              busy,
    output sdsr_pkg::cmd_t    cmd
);

    sdsr_pkg::state_t state_reg, state_next;
    logic [sdsr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [sdsr_pkg::CNT_W-1:0] cnt_prev;

    localparam logic [sdsr_pkg::CNT_W-1:0] LAST_ROW = sdsr_pkg::CNT_W'(sdsr_pkg::NUM_SETS - 1);
    localparam logic [sdsr_pkg::CNT_W-1:0] END_CNT  = sdsr_pkg::CNT_W'(sdsr_pkg::NUM_SETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdsr_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cnt_prev = cnt_reg - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        busy         = 1'b1;
        cmd.accept   = 1'b0;
        cmd.exec     = 1'b0;
        cmd.clr_wr   = 1'b0;
        cmd.swp_rd   = 1'b0;
        cmd.swp_wr   = 1'b0;
        cmd.cnt_row  = cnt_reg[sdsr_pkg::SET_W-1:0];
        cmd.prev_row = cnt_prev[sdsr_pkg::SET_W-1:0];
        unique case (state_reg)
            sdsr_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = sdsr_pkg::ST_IDLE;
                    cnt_next   = '0;
                end
            end
            sdsr_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = sdsr_pkg::ST_EXEC;
                end
            end
            sdsr_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                cnt_next   = '0;
                state_next = status.decay_req ? sdsr_pkg::ST_DECAY : sdsr_pkg::ST_IDLE;
            end
            sdsr_pkg::ST_DECAY:
            begin
                // Read row n while row n-1 is written back decremented.
                cmd.swp_rd = (cnt_reg != END_CNT);
                cmd.swp_wr = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == END_CNT)
                begin
                    state_next = sdsr_pkg::ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = sdsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sdsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsr_dp
// Datapath: set state memory, per-item row update, decay and clear rows.
// ----------------------------------------------------------------------------
module sdsr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdsr_pkg::cmd_t                    cmd,
    input  sdsr_pkg::in_word_t                in_word,
    input  logic                              cfg_wr_en,
    input  logic [sdsr_pkg::PERIOD_W-1:0]     cfg_wr_data,
    output sdsr_pkg::status_t                 status,
    output logic                              done,
    output sdsr_pkg::out_word_t               result
);

    localparam int ROW_W = $bits(sdsr_pkg::row_t);

    sdsr_pkg::in_word_t item_reg;
    logic [sdsr_pkg::PERIOD_W-1:0] period_reg;
    logic [sdsr_pkg::PERIOD_W-1:0] events_reg, events_next;
    logic done_reg;
    sdsr_pkg::out_word_t result_reg, result_next;

    sdsr_pkg::row_t r, n, dec_row, clr_row;
    logic [ROW_W-1:0] rd_data, wr_data;
    logic wr_en, rd_en;
    logic [sdsr_pkg::SET_W-1:0] wr_addr, rd_addr;

    logic [sdsr_pkg::PERIOD_W:0] ev_sum;
    logic dead_hit, decay_req;
    logic [sdsr_pkg::WAY_W-1:0] dway, best;
    logic [1:0] maxv, lift, dnew, ins;
    logic [sdsr_pkg::SIGNATURE_BITS-1:0] old_sig, new_sig;
    logic [63:0] stride;
    logic match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sdsr_pkg::DECAY_RESET;
            events_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (cmd.exec && item_reg.operation == sdsr_pkg::OP_UPDATE)
            begin
                events_reg <= events_next;
            end
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_word;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    assign r = sdsr_pkg::row_t'(rd_data);

    // Event counter wraps at the decay period; a period of zero acts like one.
    assign ev_sum      = {1'b0, events_reg} + 1'b1;
    assign events_next = (ev_sum >= {1'b0, period_reg}) ? '0
                                                        : ev_sum[sdsr_pkg::PERIOD_W-1:0];

    assign new_sig = item_reg.pc[5:0] ^ item_reg.pc[11:6] ^ {item_reg.set_index[3:0], 2'b00};
    assign old_sig = r.sig[item_reg.way];
    assign stride  = (r.prev_addr == '0) ? '0 : item_reg.paddr - r.prev_addr;
    assign match   = (r.prev_addr != '0) && (stride != '0) && (stride == r.prev_stride);

    always_comb
    begin
        n           = r;
        result_next = '0;
        decay_req   = 1'b0;
        dead_hit    = 1'b0;
        dway        = '0;
        maxv        = '0;
        best        = '0;
        lift        = '0;
        dnew        = '0;
        ins         = '0;
        if (item_reg.operation == sdsr_pkg::OP_VICTIM)
        begin
            for (int w = sdsr_pkg::NUM_WAYS - 1; w >= 0; w--)
            begin
                if (r.dead[w] == sdsr_pkg::CTR_MAX)
                begin
                    dead_hit = 1'b1;
                    dway     = sdsr_pkg::WAY_W'(w);
                end
            end
            for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
            begin
                if (r.rrpv[w] > maxv)
                begin
                    maxv = r.rrpv[w];
                    best = sdsr_pkg::WAY_W'(w);
                end
            end
            if (dead_hit)
            begin
                result_next.victim_way = dway;
                result_next.chose_dead = 1'b1;
            end
            else
            begin
                lift = sdsr_pkg::CTR_MAX - maxv;
                for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
                begin
                    n.rrpv[w] = r.rrpv[w] + lift;
                end
                result_next.victim_way = best;
            end
        end
        else if (item_reg.hit)
        begin
            if (r.reuse[old_sig] != sdsr_pkg::CTR_MAX)
            begin
                n.reuse[old_sig] = r.reuse[old_sig] + 1'b1;
            end
            n.rrpv[item_reg.way] = '0;
            n.dead[item_reg.way] = '0;
        end
        else
        begin
            if (match)
            begin
                if (r.stream != sdsr_pkg::CTR_MAX)
                begin
                    n.stream = r.stream + 1'b1;
                end
            end
            else if (r.stream != '0)
            begin
                n.stream = r.stream - 1'b1;
            end
            n.prev_stride = stride;
            n.prev_addr   = item_reg.paddr;
            if (r.reuse[old_sig] != '0)
            begin
                n.reuse[old_sig] = r.reuse[old_sig] - 1'b1;
            end
            dnew = r.dead[item_reg.way];
            if (dnew != sdsr_pkg::CTR_MAX)
            begin
                dnew = dnew + 1'b1;
            end
            n.sig[item_reg.way] = new_sig;
            if (n.stream >= sdsr_pkg::STREAM_THRESHOLD)
            begin
                n.rrpv[item_reg.way] = sdsr_pkg::CTR_MAX;
                n.dead[item_reg.way] = sdsr_pkg::CTR_MAX;
                result_next.streaming_insert = 1'b1;
            end
            else
            begin
                ins = (n.reuse[new_sig] >= sdsr_pkg::REUSE_THRESHOLD) ? 2'd0
                                                                     : sdsr_pkg::CTR_MAX;
                if (dnew == sdsr_pkg::CTR_MAX)
                begin
                    ins = sdsr_pkg::CTR_MAX;
                end
                n.rrpv[item_reg.way] = ins;
                n.dead[item_reg.way] = '0;
                decay_req = (events_next == '0);
            end
        end
    end

    assign status.decay_req = decay_req;

    always_comb
    begin
        dec_row = r;
        for (int i = 0; i < sdsr_pkg::SIG_ENTRIES; i++)
        begin
            if (r.reuse[i] != '0)
            begin
                dec_row.reuse[i] = r.reuse[i] - 1'b1;
            end
        end
        for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
        begin
            if (r.dead[w] != '0)
            begin
                dec_row.dead[w] = r.dead[w] - 1'b1;
            end
        end
    end

    always_comb
    begin
        clr_row = '0;
        for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
        begin
            clr_row.rrpv[w] = sdsr_pkg::CTR_MAX;
        end
    end

    always_comb
    begin
        wr_en   = cmd.exec || cmd.clr_wr || cmd.swp_wr;
        wr_addr = item_reg.set_index;
        wr_data = ROW_W'(n);
        if (cmd.clr_wr)
        begin
            wr_addr = cmd.cnt_row;
            wr_data = ROW_W'(clr_row);
        end
        else if (cmd.swp_wr)
        begin
            wr_addr = cmd.prev_row;
            wr_data = ROW_W'(dec_row);
        end
        rd_en   = cmd.accept || cmd.swp_rd;
        rd_addr = cmd.accept ? in_word.set_index : cmd.cnt_row;
    end

    sdsr_ram #(
        .WIDTH(ROW_W),
        .DEPTH(sdsr_pkg::NUM_SETS)
    ) u_row_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

endmodule

// File: rtl/ship_deadblock_stream_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_deadblock_stream_replacement_top
// Signature and dead-block driven RRIP replacement with stream detection.
// ----------------------------------------------------------------------------
// After reset the block clears its 2048-row set memory, one row a cycle, and
// holds busy high until every row is cleared. For each word the set's row is
// first read from the single-port-read memory, then updated and written back;
// the result strobes on done in the cycle after the write-back and must be
// taken then. A fill that triggers the periodic decay keeps busy high while
// every row is read, decremented and written back.
module ship_deadblock_stream_replacement_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sdsr_pkg::in_word_t            in_word,
    output logic                          done,
    output sdsr_pkg::out_word_t           result,
    input  logic                          cfg_wr_en,
    input  logic [sdsr_pkg::PERIOD_W-1:0] cfg_wr_data
);

    sdsr_pkg::cmd_t    cmd;
    sdsr_pkg::status_t status;

    sdsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .busy  (busy),
        .cmd   (cmd)
    );

    sdsr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_word    (in_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .status     (status),
        .done       (done),
        .result     (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted word");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobed in two consecutive cycles");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result appeared without work in progress");

endmodule
